/* src/assert_macros.svh */
// Assertion macros shared by the search block RTL.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds in the same cycle as trig.
`define CHK_SAME(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("check failed in sorted key search");

// Check that cond holds in the cycle after trig.
`define CHK_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("check failed in sorted key search");

`endif

/* src/sks_pkg.sv */
// Shared types and constants for the sorted key search block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sks_pkg;

  localparam int KEY_W         = 64;
  localparam int ID_W          = 10;
  localparam int POS_W         = 10;
  localparam int CNT_W         = 11;
  localparam int WIDE_W        = 17;   // holds any depth up to 65536
  localparam int DEPTH_DEFAULT = 1024;
  localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [POS_W-1:0] position;
    logic [KEY_W-1:0] search_key;
    logic [ID_W-1:0]  entry_id;
  } in_t;

  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] match_id;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } entry_t;

  typedef struct packed {
    logic hit;     // key equals the entry
    logic below;   // key is below the entry
    logic empty;   // narrowed interior holds no position
  } step_flags_t;

endpackage

`default_nettype wire

/* src/sks_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on sks_pkg for default sizes.
`timescale 1ns / 1ps
`default_nettype none

module sks_ram
  import sks_pkg::*;
#(
  parameter int WIDTH = $bits(entry_t),
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word, read returns the old contents
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/sks_step.sv */
// Shared compare and narrowing unit: one 64-bit compare per probe.
// Depends on sks_pkg for key width and the flag struct.
`timescale 1ns / 1ps
`default_nettype none

module sks_step
  import sks_pkg::*;
#(
  parameter int AW = 10
) (
  input  wire logic [KEY_W-1:0] key,
  input  wire logic [KEY_W-1:0] ent_key,
  input  wire logic [AW:0]      lo,
  input  wire logic [AW:0]      hi,
  input  wire logic [AW-1:0]    probe,
  output step_flags_t           flags,
  output logic      [AW:0]      lo_next,
  output logic      [AW:0]      hi_next,
  output logic      [AW-1:0]    probe_next
);

  logic [AW+1:0] sum;

  // Compare, then narrow the interior around the probe
  always_comb begin
    flags.hit   = (key == ent_key);
    flags.below = (key < ent_key);
    if (flags.below) begin
      lo_next = lo;
      hi_next = {1'b0, probe} - (AW+1)'(1);
    end else begin
      lo_next = {1'b0, probe} + (AW+1)'(1);
      hi_next = hi;
    end
    flags.empty = (hi_next < lo_next);
    sum         = {1'b0, lo_next} + {1'b0, hi_next};
    probe_next  = sum[AW:1];
  end

endmodule

`default_nettype wire

/* src/sorted_key_search_with_hint.sv */
// Sorted key search with a remembered starting probe.
// Channels: a command beat is taken when start is high and busy is low.
//   A write beat (cmd = CMD_WRITE) stores key and id at position; busy
//   stays low and no result follows. A lookup beat raises busy until its
//   result is out.
// Lookup: entry 0 is compared first, then the last entry, then a binary
//   search over the interior starting at the position of the last interior
//   hit when that hit lies inside the interior, else at its middle. One
//   table read and one 64-bit compare per cycle in the shared step unit;
//   the single RAM read port sets the pace.
// Ending: a lookup ends at entry 0 for a key at or below it, at the last
//   entry for a key at or above it, and otherwise when an interior probe
//   hits, when the narrowed interior is empty, or at once if there is none.
// Results: done is high for exactly one cycle with found and match_id; a
//   miss gives match_id 0. The receiver cannot stall; busy drops in the
//   cycle done is high, so the next beat may be taken then.
// Reset: entry_count returns to 1024, the hint to 1, no result pending.
//   The table itself is not cleared; entries must be written before use.
// Config: cfg_we/cfg_data write entry_count; user keeps to idle, unchecked.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sorted_key_search_with_hint
  import sks_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire in_t              item,
  output logic                  busy,
  output logic                  done,
  output out_t                  result,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_END0  = 3'd1;
  localparam logic [2:0] S_END1  = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [KEY_W-1:0] lookup_key;
  logic [AW:0]      lo;
  logic [AW:0]      hi;
  logic [AW-1:0]    probe;
  logic [AW-1:0]    hint;
  logic [CNT_W-1:0] entry_count;

  logic [WIDE_W-1:0] cnt_wide;
  logic [AW-1:0]     last;
  logic [AW-1:0]     first_probe;
  logic [AW-1:0]     raddr;
  logic              wr_en;
  logic              accept;
  logic              finish;
  logic              fin_found;
  logic [ID_W-1:0]   fin_id;
  entry_t            wr_entry;
  entry_t            rd_entry;
  logic [$bits(entry_t)-1:0] rd_word;
  step_flags_t       flags;
  logic [AW:0]       lo_next;
  logic [AW:0]       hi_next;
  logic [AW-1:0]     probe_next;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Clamp the loaded count to 1 .. TABLE_DEPTH, take the last position and pick the first probe
  always_comb begin
    cnt_wide = WIDE_W'(entry_count);
    if (cnt_wide == '0) begin
      last = '0;
    end else if (cnt_wide >= WIDE_W'(TABLE_DEPTH)) begin
      last = AW'(TABLE_DEPTH - 1);
    end else begin
      last = AW'(cnt_wide - WIDE_W'(1));
    end
    if ((hint >= AW'(1)) && (hint < last)) begin
      first_probe = hint;
    end else begin
      first_probe = last >> 1;
    end
  end

  // Table writes: drop positions beyond the table
  assign wr_en          = accept && (item.cmd == CMD_WRITE) &&
                          (WIDE_W'(item.position) < WIDE_W'(TABLE_DEPTH));
  assign wr_entry.key   = item.search_key;
  assign wr_entry.id    = item.entry_id;

  sks_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(AW'(item.position)),
    .wdata(wr_entry),
    .raddr(raddr),
    .rdata(rd_word)
  );

  assign rd_entry = entry_t'(rd_word);

  sks_step #(
    .AW(AW)
  ) u_step (
    .key       (lookup_key),
    .ent_key   (rd_entry.key),
    .lo        (lo),
    .hi        (hi),
    .probe     (probe),
    .flags     (flags),
    .lo_next   (lo_next),
    .hi_next   (hi_next),
    .probe_next(probe_next)
  );

  // Sequencer: pick the next read address and decide when a lookup ends
  always_comb begin
    state_next = state;
    raddr      = '0;
    finish     = 1'b0;
    fin_found  = 1'b0;
    fin_id     = '0;
    case (state)
      S_IDLE: begin
        if (accept && (item.cmd == CMD_LOOKUP)) begin
          state_next = S_END0;
        end
      end
      S_END0: begin
        if (flags.below || flags.hit) begin
          finish    = 1'b1;
          fin_found = flags.hit;
        end else begin
          raddr      = last;
          state_next = S_END1;
        end
      end
      S_END1: begin
        if (!flags.below) begin
          finish    = 1'b1;
          fin_found = flags.hit;
        end else if ({1'b0, last} < (AW+1)'(2)) begin
          finish = 1'b1;
        end else begin
          raddr      = first_probe;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (flags.hit) begin
          finish    = 1'b1;
          fin_found = 1'b1;
        end else if (flags.empty) begin
          finish = 1'b1;
        end else begin
          raddr = probe_next;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (finish) begin
      state_next = S_IDLE;
      if (fin_found) begin
        fin_id = rd_entry.id;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      hint        <= AW'(1);
      entry_count <= CNT_RESET;
    end else begin
      state <= state_next;
      done  <= finish;
      if (cfg_we) begin
        entry_count <= cfg_data;
      end
      if ((state == S_PROBE) && flags.hit) begin
        hint <= probe;
      end
    end
  end

  // Datapath registers: hold the key, advance the interior bounds, capture the result
  always_ff @(posedge clk) begin
    if (accept) begin
      lookup_key <= item.search_key;
    end
    if ((state == S_END1) && (state_next == S_PROBE)) begin
      lo    <= (AW+1)'(1);
      hi    <= {1'b0, last} - (AW+1)'(1);
      probe <= first_probe;
    end else if ((state == S_PROBE) && !finish) begin
      lo    <= lo_next;
      hi    <= hi_next;
      probe <= probe_next;
    end
    if (finish) begin
      result.found    <= fin_found;
      result.match_id <= fin_id;
    end
  end

  `CHK_SAME(a_done_idle, done, !busy)
  `CHK_SAME(a_miss_zero, done && !result.found, result.match_id == '0)
  `CHK_NEXT(a_write_no_busy, accept && (item.cmd == CMD_WRITE), !busy)
  `CHK_SAME(a_probe_inside, state == S_PROBE, (lo <= {1'b0, probe}) && ({1'b0, probe} <= hi))

endmodule

`default_nettype wire
